// ===== rtl/core/ckhm_pkg.sv =====
// ----------------------------------------------------------------------------
// ckhm_pkg
// Types and codes shared by the coordinate-keyed chained hash map.
// ----------------------------------------------------------------------------
package ckhm_pkg;

	typedef enum logic [2:0] {
		K_PUT      = 3'd0,
		K_RM_HANDLE = 3'd1,
		K_RM_KEY   = 3'd2,
		K_GET      = 3'd3,
		K_CLEAR    = 3'd4,
		K_FIRST    = 3'd5,
		K_NEXT     = 3'd6,
		K_NONE     = 3'd7
	} kind_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [31:0]        handle;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        found_handle;
		logic signed [31:0] found_x;
		logic signed [31:0] found_y;
		logic signed [31:0] found_z;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_EVAL,
		S_UNLINK,
		S_SCAN,
		S_SCANRD,
		S_CLEAR,
		S_OUT
	} state_t;

endpackage

// ===== rtl/core/coordinate_keyed_chained_hash_map.sv =====
// Put, remove and get read the bucket head and then walk the chain entry by entry
// (a get ends at its hit); first/next scan the buckets in turn; clear sweeps the
// bucket heads and free stack. One item at a time: the result holds
// until taken, then the block returns to idle before the next item is accepted.
// Reset: asynchronous clear of control state, then a sweep over the bucket
// heads and free stack with in_ready low.
// ----------------------------------------------------------------------------
// coordinate_keyed_chained_hash_map
// Spatial hash table with pooled chains in on-chip memories.
// ----------------------------------------------------------------------------
module coordinate_keyed_chained_hash_map #(
	parameter int SIDE = 8,
	parameter int POOL_ENTRIES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ckhm_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ckhm_pkg::rsp_t  out_data
);
	import ckhm_pkg::*;

	localparam int SB = $clog2(SIDE);
	localparam int NB = SIDE * SIDE * SIDE;
	localparam int BW = $clog2(NB);
	localparam int EW = $clog2(POOL_ENTRIES);
	localparam int LW = EW + 1;
	localparam int CW = (BW > EW) ? BW + 1 : EW + 1;
	localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

	// memories
	logic [LW-1:0] heads_mem [NB];
	logic [95:0]   key_mem   [POOL_ENTRIES];
	logic [31:0]   val_mem   [POOL_ENTRIES];
	logic [LW-1:0] next_mem  [POOL_ENTRIES];
	logic [EW-1:0] free_mem  [POOL_ENTRIES];

	state_t state_q, state_d;
	req_t req_q;
	rsp_t rsp_q, rsp_d;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q;
	logic [LW-1:0] fcnt_q;
	logic [CW-1:0] sweep_q;
	logic init_q;

	// registered read data
	logic [LW-1:0] head_rd_q, next_rd_q;
	logic [95:0]   key_rd_q;
	logic [31:0]   val_rd_q;
	logic [EW-1:0] free_rd_q;

	// bucket index: mixed radix of the low coordinate bits
	function automatic logic [BW-1:0] bucket(input req_t r);
		logic [3*SB-1:0] v;
		v = {r.coord_z[SB-1:0], r.coord_y[SB-1:0], r.coord_x[SB-1:0]};
		return v[BW-1:0];
	endfunction

	// memory access controls
	logic          h_we, n_we, e_we, f_we;
	logic [BW-1:0] h_wa, h_ra;
	logic [LW-1:0] h_wd, n_wd;
	logic [EW-1:0] n_wa, e_ra, f_wa, f_wd, f_ra;
	logic          hit;

	always_ff @(posedge clk) begin
		if (h_we) heads_mem[h_wa] <= h_wd;
		if (n_we) next_mem[n_wa] <= n_wd;
		if (e_we) begin
			key_mem[n_wa] <= {req_q.coord_x, req_q.coord_y, req_q.coord_z};
			val_mem[n_wa] <= req_q.handle;
		end
		if (f_we) free_mem[f_wa] <= f_wd;
		head_rd_q <= heads_mem[h_ra];
		next_rd_q <= next_mem[e_ra];
		key_rd_q  <= key_mem[e_ra];
		val_rd_q  <= val_mem[e_ra];
		free_rd_q <= free_mem[f_ra];
	end

	assign hit = (req_q.kind == K_RM_HANDLE) ? (val_rd_q == req_q.handle) :
		(key_rd_q == {req_q.coord_x, req_q.coord_y, req_q.coord_z});

	assign in_ready  = (state_q == S_IDLE) && !init_q;
	assign out_valid = (state_q == S_OUT);
	assign out_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			init_q  <= 1'b1;
			sweep_q <= '0;
			fcnt_q  <= NIL;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				if (state_d != S_CLEAR) begin
					init_q  <= 1'b0;
					sweep_q <= '0;
					fcnt_q  <= NIL;
				end else begin
					sweep_q <= sweep_q + 1'b1;
				end
			end else if (state_q == S_SCAN) begin
				sweep_q <= sweep_q + 1'b1;
			end else if (state_q == S_IDLE && in_valid) begin
				sweep_q <= (in_data.kind == K_NEXT) ? CW'(bucket(in_data)) + 1'b1 : '0;
			end
			// free count moves only when the entry write completes
			if (state_q == S_WALK && req_q.kind == K_PUT && cur_q == NIL)
				fcnt_q <= fcnt_q - 1'b1;
			if (state_q == S_UNLINK) begin
				if (req_q.kind == K_PUT) fcnt_q <= fcnt_q - 1'b1;
				else if (fcnt_q < NIL) fcnt_q <= fcnt_q + 1'b1;
			end
		end
	end

	// response fields for the state that hands over to S_OUT
	always_comb begin
		rsp_d = '0;
		rsp_d.status = ST_OK;
		case (state_q)
			S_HEAD:   if (fcnt_q == '0) rsp_d.status = ST_FULL;
			S_WALK:   if (cur_q == NIL && req_q.kind != K_PUT) rsp_d.status = ST_MISS;
			S_SCAN:   rsp_d.status = ST_MISS;
			S_IDLE:   rsp_d.status = ST_MISS;
			S_EVAL: begin
				rsp_d.found_handle = val_rd_q;
				rsp_d.found_x = key_rd_q[95:64];
				rsp_d.found_y = key_rd_q[63:32];
				rsp_d.found_z = key_rd_q[31:0];
			end
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
			bkt_q <= bucket(in_data);
		end
		if (state_q == S_HEAD) begin
			cur_q  <= head_rd_q;
			prev_q <= NIL;
		end
		if (state_q == S_EVAL && (!hit || req_q.kind == K_PUT)) begin
			prev_q <= cur_q;
			cur_q  <= next_rd_q;
		end
		if (state_q == S_SCANRD) bkt_q <= sweep_q[BW-1:0] - 1'b1;
		if (state_d == S_OUT && state_q != S_OUT) rsp_q <= rsp_d;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		h_we = 1'b0; h_wa = bkt_q; h_wd = NIL; h_ra = bkt_q;
		n_we = 1'b0; e_we = 1'b0; n_wa = cur_q[EW-1:0]; n_wd = NIL;
		e_ra = cur_q[EW-1:0];
		f_we = 1'b0; f_wa = fcnt_q[EW-1:0]; f_wd = cur_q[EW-1:0];
		f_ra = EW'(fcnt_q - 1'b1);
		case (state_q)
			S_IDLE: begin
				h_ra = bucket(in_data);
				if (in_valid) begin
					case (in_data.kind)
						K_PUT, K_RM_HANDLE, K_RM_KEY, K_GET: state_d = S_HEAD;
						K_CLEAR: state_d = S_CLEAR;
						K_FIRST, K_NEXT: state_d = S_SCAN;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_HEAD: begin
				// head and top of free stack are valid now
				if (req_q.kind == K_PUT && fcnt_q == '0) state_d = S_OUT;
				else state_d = S_WALK;
			end
			S_WALK: begin
				// put: cur_q is tail candidate; others: read entry
				if (req_q.kind == K_PUT) begin
					n_wa = free_rd_q;
					if (cur_q == NIL) begin
						n_we = 1'b1; e_we = 1'b1;
						h_we = 1'b1; h_wd = LW'(free_rd_q);
						state_d = S_OUT;
					end else state_d = S_EVAL;
				end else if (cur_q == NIL) state_d = S_OUT;
				else state_d = S_EVAL;
			end
			S_EVAL: begin
				if (req_q.kind == K_PUT) begin
					if (next_rd_q == NIL) begin
						n_we = 1'b1; n_wd = LW'(free_rd_q);
						state_d = S_UNLINK;
					end else state_d = S_WALK;
				end else if (hit) begin
					state_d = (req_q.kind == K_GET) ? S_OUT : S_UNLINK;
				end else state_d = S_WALK;
			end
			S_UNLINK: begin
				if (req_q.kind == K_PUT) begin
					n_wa = free_rd_q; n_we = 1'b1; e_we = 1'b1;
				end else begin
					if (prev_q == NIL) begin
						h_we = 1'b1; h_wd = next_rd_q;
					end else begin
						n_wa = prev_q[EW-1:0]; n_we = 1'b1; n_wd = next_rd_q;
					end
					f_we = (fcnt_q < NIL);
				end
				state_d = S_OUT;
			end
			S_SCAN: begin
				h_ra = sweep_q[BW-1:0];
				if (sweep_q >= CW'(NB)) state_d = S_OUT;
				else state_d = S_SCANRD;
			end
			S_SCANRD: begin
				if (head_rd_q < NIL) begin
					e_ra = head_rd_q[EW-1:0];
					state_d = S_EVAL;
				end else state_d = S_SCAN;
			end
			S_CLEAR: begin
				h_wa = sweep_q[BW-1:0];
				h_we = (sweep_q < CW'(NB));
				f_wa = sweep_q[EW-1:0];
				f_wd = EW'(POOL_ENTRIES - 1) - sweep_q[EW-1:0];
				f_we = (sweep_q < CW'(POOL_ENTRIES));
				if (sweep_q >= CW'(NB - 1) && sweep_q >= CW'(POOL_ENTRIES - 1))
					state_d = init_q ? S_IDLE : S_OUT;
			end
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// scan hit: head entry data is registered by the time S_EVAL runs
		if (state_q == S_EVAL && req_q.kind != K_PUT && req_q.kind != K_RM_HANDLE
			&& req_q.kind != K_RM_KEY && req_q.kind != K_GET) state_d = S_OUT;
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n) fcnt_q <= NIL)
		else $error("free count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("result changed while stalled");

endmodule

// ===== verif/tb_coordinate_keyed_chained_hash_map.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coordinate_keyed_chained_hash_map
// Drives map operations through the request channel, predicts every response
// with a behavioral copy of the map (chains, free stack, bucket heads) and
// compares each response field by field, with and without random idling on both sides.
// ----------------------------------------------------------------------------
module tb_coordinate_keyed_chained_hash_map;
	import ckhm_pkg::*;

	localparam int SIDE = 8;
	localparam int POOL_ENTRIES = 1024;
	localparam int NBKT = SIDE * SIDE * SIDE;
	localparam int NIL = POOL_ENTRIES;
	localparam int SBITS = $clog2(SIDE);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;

	coordinate_keyed_chained_hash_map #(.SIDE(SIDE), .POOL_ENTRIES(POOL_ENTRIES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// shadow map
	int unsigned heads[NBKT];
	logic [31:0] ent_x[POOL_ENTRIES];
	logic [31:0] ent_y[POOL_ENTRIES];
	logic [31:0] ent_z[POOL_ENTRIES];
	logic [31:0] ent_h[POOL_ENTRIES];
	int unsigned ent_next[POOL_ENTRIES];
	int unsigned free_stk[POOL_ENTRIES];
	int unsigned free_cnt;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	int send_idle = 32;
	int recv_idle = 45;
	// item taken at the last rising edge
	bit in_taken = 0;

	// keys of the latest puts (up to 64), reused to hit chains
	req_t used_keys[$];

	function automatic void map_clear();
		for (int b = 0; b < NBKT; b++) heads[b] = NIL;
		for (int i = 0; i < POOL_ENTRIES; i++) free_stk[i] = POOL_ENTRIES - 1 - i;
		free_cnt = POOL_ENTRIES;
	endfunction

	function automatic int unsigned bucket_index(req_t r);
		logic [SBITS-1:0] bx, by, bz;
		bx = r.coord_x[SBITS-1:0];
		by = r.coord_y[SBITS-1:0];
		bz = r.coord_z[SBITS-1:0];
		return bx + by * SIDE + bz * SIDE * SIDE;
	endfunction

	function automatic rsp_t entry_rsp(int unsigned e);
		rsp_t r;
		r.status = ST_OK;
		r.found_handle = ent_h[e];
		r.found_x = ent_x[e];
		r.found_y = ent_y[e];
		r.found_z = ent_z[e];
		return r;
	endfunction

	function automatic rsp_t scan_buckets(int unsigned start);
		rsp_t r;
		r = '0;
		r.status = ST_MISS;
		for (int unsigned b = start; b < NBKT; b++)
			if (heads[b] < NIL) return entry_rsp(heads[b]);
		return r;
	endfunction

	function automatic bit key_hit(int unsigned e, req_t q);
		return ent_x[e] == q.coord_x && ent_y[e] == q.coord_y && ent_z[e] == q.coord_z;
	endfunction

	// apply one operation to the shadow map and return its response
	function automatic rsp_t map_apply(req_t q);
		rsp_t r;
		int unsigned b, e, cur, prev;
		bit hit;
		r = '0;
		b = bucket_index(q);
		case (kind_t'(q.kind))
			K_PUT: begin
				if (free_cnt == 0) begin
					r.status = ST_FULL;
				end else begin
					free_cnt--;
					e = free_stk[free_cnt];
					ent_x[e] = q.coord_x;
					ent_y[e] = q.coord_y;
					ent_z[e] = q.coord_z;
					ent_h[e] = q.handle;
					ent_next[e] = NIL;
					if (heads[b] >= NIL) begin
						heads[b] = e;
					end else begin
						cur = heads[b];
						while (ent_next[cur] < NIL) cur = ent_next[cur];
						ent_next[cur] = e;
					end
				end
			end
			K_RM_HANDLE, K_RM_KEY: begin
				r.status = ST_MISS;
				prev = NIL;
				cur = heads[b];
				while (cur < NIL) begin
					hit = (q.kind == K_RM_HANDLE) ? (ent_h[cur] == q.handle) : key_hit(cur, q);
					if (hit) begin
						if (prev >= NIL) heads[b] = ent_next[cur];
						else ent_next[prev] = ent_next[cur];
						if (free_cnt < POOL_ENTRIES) begin
							free_stk[free_cnt] = cur;
							free_cnt++;
						end
						r.status = ST_OK;
						break;
					end
					prev = cur;
					cur = ent_next[cur];
				end
			end
			K_GET: begin
				r.status = ST_MISS;
				cur = heads[b];
				while (cur < NIL) begin
					if (key_hit(cur, q)) begin
						r = entry_rsp(cur);
						break;
					end
					cur = ent_next[cur];
				end
			end
			K_CLEAR: map_clear();
			K_FIRST: r = scan_buckets(0);
			K_NEXT: r = scan_buckets(b + 1);
			default: r.status = ST_MISS;
		endcase
		return r;
	endfunction

	function automatic req_t make_req(kind_t k, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [31:0] h);
		req_t q;
		q.kind = k;
		q.coord_x = x;
		q.coord_y = y;
		q.coord_z = z;
		q.handle = h;
		return q;
	endfunction

	// random operation: mostly keys from a small set so chains grow and get hit
	function automatic req_t random_req();
		req_t q;
		int sel;
		q.coord_x = $urandom;
		q.coord_y = $urandom;
		q.coord_z = $urandom;
		q.handle = $urandom;
		sel = $urandom_range(0, 99);
		if (sel < 40) q.kind = K_PUT;
		else if (sel < 52) q.kind = K_RM_HANDLE;
		else if (sel < 64) q.kind = K_RM_KEY;
		else if (sel < 82) q.kind = K_GET;
		else if (sel < 83) q.kind = K_CLEAR;
		else if (sel < 89) q.kind = K_FIRST;
		else if (sel < 98) q.kind = K_NEXT;
		else q.kind = K_NONE;
		if (used_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
			req_t k;
			k = used_keys[$urandom_range(0, used_keys.size() - 1)];
			q.coord_x = k.coord_x;
			q.coord_y = k.coord_y;
			q.coord_z = k.coord_z;
			if (q.kind == K_RM_HANDLE && $urandom_range(0, 2) != 0) q.handle = k.handle;
		end else if ($urandom_range(0, 1)) begin
			// small coordinates crowd a few buckets
			q.coord_x = $urandom_range(0, 3) - 2;
			q.coord_y = $urandom_range(0, 3) - 2;
			q.coord_z = $urandom_range(0, 1);
		end
		if ($urandom_range(0, 3) == 0) q.handle = $urandom_range(0, 7);
		if (q.kind == K_PUT) begin
			used_keys.push_back(q);
			if (used_keys.size() > 64) void'(used_keys.pop_front());
		end
		return q;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_taken) begin
			// previous item accepted or none in flight
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				in_data <= pending_reqs.pop_front();
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// prediction on accept, checking on response
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_rsps.push_back(map_apply(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response status=%0d", out_data.status);
				errors++;
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (out_data.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_data.status); errors++;
				end
				if (out_data.found_handle !== e.found_handle) begin
					$error("found_handle exp %h got %h", e.found_handle,
						out_data.found_handle); errors++;
				end
				if (out_data.found_x !== e.found_x) begin
					$error("found_x exp %0d got %0d", e.found_x, out_data.found_x); errors++;
				end
				if (out_data.found_y !== e.found_y) begin
					$error("found_y exp %0d got %0d", e.found_y, out_data.found_y); errors++;
				end
				if (out_data.found_z !== e.found_z) begin
					$error("found_z exp %0d got %0d", e.found_z, out_data.found_z); errors++;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		in_data = '0;
		map_clear();
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: empty map, extremes, every operation, chain handling
		pending_reqs.push_back(make_req(K_FIRST, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_GET, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_RM_KEY, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_PUT, 32'h80000000, 32'h7fffffff, 32'hffffffff,
			32'hffffffff));
		pending_reqs.push_back(make_req(K_PUT, 32'h7fffffff, 32'h80000000, 0, 0));
		pending_reqs.push_back(make_req(K_PUT, 8, 0, 0, 32'h11));
		pending_reqs.push_back(make_req(K_PUT, 0, 0, 0, 32'h22));
		pending_reqs.push_back(make_req(K_PUT, 8, 0, 0, 32'h33));
		pending_reqs.push_back(make_req(K_GET, 8, 0, 0, 0));
		pending_reqs.push_back(make_req(K_GET, 16, 0, 0, 0));
		pending_reqs.push_back(make_req(K_FIRST, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_NEXT, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_NEXT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0));
		// remove by handle frees a match in the key's bucket whatever its key
		pending_reqs.push_back(make_req(K_RM_HANDLE, 16, 0, 0, 32'h22));
		pending_reqs.push_back(make_req(K_RM_HANDLE, 0, 0, 0, 32'h99));
		pending_reqs.push_back(make_req(K_RM_KEY, 8, 0, 0, 0));
		pending_reqs.push_back(make_req(K_GET, 8, 0, 0, 0));
		pending_reqs.push_back(make_req(K_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff));
		pending_reqs.push_back(make_req(K_CLEAR, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_FIRST, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_RM_KEY, 5, 0, 0, 0));
		pending_reqs.push_back(make_req(K_PUT, 5, 0, 0, 32'h55));
		pending_reqs.push_back(make_req(K_PUT, 6, 0, 0, 32'h66));
		pending_reqs.push_back(make_req(K_CLEAR, 0, 0, 0, 0));

		// random, three phases with different idling
		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < 310; i++) pending_reqs.push_back(random_req());
			wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
			if (p == 0) begin
				send_idle = 45;
				recv_idle = 32;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
		end
		repeat (2000) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#60_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ckhm_pkg.sv
rtl/core/coordinate_keyed_chained_hash_map.sv
verif/tb_coordinate_keyed_chained_hash_map.sv
